// ----- sv/fisc_pkg.sv -----
// ----------------------------------------------------------------------------
// fisc_pkg
// Shared glyph codes, the segment table and the glyph bundle type for the
// floor indicator scan core.
// ----------------------------------------------------------------------------
package fisc_pkg;

  localparam int GLYPH_W = 5;
  localparam int SEG_W   = 8;
  localparam int DIG_W   = 4;
  localparam int FLOOR_W = 8;
  localparam int MOTION_W = 3;
  localparam int SCAN_W  = 2;

  typedef logic [GLYPH_W-1:0] glyph_t;

  localparam glyph_t G_ZERO  = 5'd0;
  localparam glyph_t G_S     = 5'd5;
  localparam glyph_t G_B     = 5'd11;
  localparam glyph_t G_P     = 5'd22;
  localparam glyph_t G_DASH  = 5'd25;
  localparam glyph_t G_BLANK = 5'd26;

  localparam logic [MOTION_W-1:0] MOT_STOP   = 3'd0;
  localparam logic [MOTION_W-1:0] MOT_UP     = 3'd1;
  localparam logic [MOTION_W-1:0] MOT_DOWN   = 3'd2;
  localparam logic [MOTION_W-1:0] MOT_GROUND = 3'd3;

  localparam logic [SCAN_W-1:0] POS_UNITS = 2'd0;
  localparam logic [SCAN_W-1:0] POS_TENS  = 2'd1;
  localparam logic [SCAN_W-1:0] POS_THIRD = 2'd2;
  localparam logic [SCAN_W-1:0] POS_DIR   = 2'd3;

  typedef struct packed {
    glyph_t units_g;
    glyph_t tens_g;
    logic   dir_load;
    glyph_t dir_g;
  } glyph_set_t;

  function automatic logic [SEG_W-1:0] glyph_pattern(input glyph_t idx);
    logic [SEG_W-1:0] p;
    case (idx)
      5'd0:  p = 8'h3F;
      5'd1:  p = 8'h06;
      5'd2:  p = 8'h5B;
      5'd3:  p = 8'h4F;
      5'd4:  p = 8'h66;
      5'd5:  p = 8'h6D;
      5'd6:  p = 8'h7D;
      5'd7:  p = 8'h07;
      5'd8:  p = 8'h7F;
      5'd9:  p = 8'h6F;
      5'd10: p = 8'h5F;
      5'd11: p = 8'h7C;
      5'd12: p = 8'h58;
      5'd13: p = 8'h5E;
      5'd14: p = 8'h7B;
      5'd15: p = 8'h71;
      5'd16: p = 8'h77;
      5'd17: p = 8'h39;
      5'd18: p = 8'h79;
      5'd19: p = 8'h76;
      5'd20: p = 8'h1E;
      5'd21: p = 8'h38;
      5'd22: p = 8'h73;
      5'd23: p = 8'h3E;
      5'd24: p = 8'h80;
      5'd25: p = 8'h40;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/floor_indicator_seven_segment_scan_core.sv -----
// ----------------------------------------------------------------------------
// floor_indicator_seven_segment_scan_core
// Four-digit multiplexed seven-segment driver for a lift floor indicator.
//
//   channel  ports                                   direction
//   in       in_valid, in_stall, in_floor, in_motion  item in
//   out      out_valid, out_stall, out_segments_n,    item out
//            out_digit_enable_n
//
// One item per cycle while out_stall is low; an item passes the input register, then the result register.
// Throughput is set by the single decode path between those registers.
// rst_n is synchronous: scan position and direction glyph return to zero.
// A stalled result holds; the input register still takes one more item.
// ----------------------------------------------------------------------------
module floor_indicator_seven_segment_scan_core
  import fisc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [FLOOR_W-1:0]  in_floor,
  input  logic        [MOTION_W-1:0] in_motion,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic        [SEG_W-1:0]    out_segments_n,
  output logic        [DIG_W-1:0]    out_digit_enable_n
);

  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [FLOOR_W-1:0]  floor_r;
  logic        [MOTION_W-1:0] motion_r;
  logic                       take_ok;
  logic                       load;
  glyph_set_t                 glyphs;

  assign in_stall = s1_valid_r && !take_ok;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (take_ok) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      floor_r  <= in_floor;
      motion_r <= in_motion;
    end
  end

  fisc_decode u_decode (
    .floor  (floor_r),
    .motion (motion_r),
    .glyphs (glyphs)
  );

  fisc_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (s1_valid_r),
    .glyphs             (glyphs),
    .take_ok            (take_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_segments_n     (out_segments_n),
    .out_digit_enable_n (out_digit_enable_n)
  );

endmodule

// ----- sv/fisc_decode.sv -----
// ----------------------------------------------------------------------------
// fisc_decode
// Turns a floor number and motion code into units, tens and direction glyphs.
// ----------------------------------------------------------------------------
module fisc_decode
  import fisc_pkg::*;
(
  input  logic signed [FLOOR_W-1:0]  floor,
  input  logic        [MOTION_W-1:0] motion,
  output glyph_set_t                 glyphs
);

  logic                neg;
  logic                zero;
  logic [FLOOR_W-1:0]  mag;
  logic [15:0]         prod;
  logic [3:0]          q10;
  logic [7:0]          q10x10;
  logic [3:0]          units;
  logic [3:0]          tens;

  always_comb begin
    neg    = floor[FLOOR_W-1];
    zero   = (floor == '0);
    mag    = neg ? (~floor + 8'd1) : floor;
    prod   = {8'd0, mag} * 16'd205;
    q10    = prod[14:11];
    q10x10 = {4'd0, q10} * 8'd10;
    units  = 4'(mag - q10x10);
    tens   = (q10 >= 4'd10) ? (q10 - 4'd10) : q10;

    if (zero) begin
      glyphs.tens_g  = G_P;
      glyphs.units_g = G_B;
    end else if (!neg) begin
      glyphs.tens_g  = (tens == 4'd0) ? G_BLANK : {1'b0, tens};
      glyphs.units_g = {1'b0, units};
    end else begin
      glyphs.tens_g  = G_DASH;
      glyphs.units_g = {1'b0, units};
    end

    glyphs.dir_load = 1'b1;
    glyphs.dir_g    = G_BLANK;
    if (zero && motion != MOT_UP && motion != MOT_DOWN) begin
      glyphs.dir_g = G_BLANK;
    end else begin
      case (motion)
        MOT_STOP:   glyphs.dir_g = G_BLANK;
        MOT_UP:     glyphs.dir_g = G_S;
        MOT_DOWN:   glyphs.dir_g = G_B;
        MOT_GROUND: glyphs.dir_g = neg ? G_S : G_B;
        default:    glyphs.dir_load = 1'b0;
      endcase
    end
  end

endmodule

// ----- sv/fisc_scan.sv -----
// ----------------------------------------------------------------------------
// fisc_scan
// Holds scan position and direction glyph, selects the digit for each item
// and keeps the result register.
// ----------------------------------------------------------------------------
module fisc_scan
  import fisc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  glyph_set_t        glyphs,
  output logic              take_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SEG_W-1:0]  out_segments_n,
  output logic [DIG_W-1:0]  out_digit_enable_n
);

  logic [SCAN_W-1:0] scan_r,  scan_nxt;
  glyph_t            dir_r,   dir_nxt;
  logic              valid_r, valid_nxt;
  logic [SEG_W-1:0]  seg_r,   seg_nxt;
  logic [DIG_W-1:0]  dig_r,   dig_nxt;
  logic              advance;
  glyph_t            sel;

  assign take_ok = !valid_r || !out_stall;
  assign advance = item_valid && take_ok;

  always_comb begin
    dir_nxt   = glyphs.dir_load ? glyphs.dir_g : dir_r;
    case (scan_r)
      POS_UNITS: sel = glyphs.units_g;
      POS_TENS:  sel = glyphs.tens_g;
      POS_THIRD: sel = G_BLANK;
      default:   sel = dir_nxt;
    endcase
    seg_nxt   = ~glyph_pattern(sel);
    dig_nxt   = ~(DIG_W'(1) << scan_r);
    scan_nxt  = scan_r + SCAN_W'(1);
    valid_nxt = advance ? 1'b1 : (out_stall ? valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      dir_r   <= G_ZERO;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (advance) begin
        scan_r <= scan_nxt;
        dir_r  <= dir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      seg_r <= seg_nxt;
      dig_r <= dig_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_segments_n     = seg_r;
  assign out_digit_enable_n = dig_r;

endmodule

// ----- verif/floor_indicator_seven_segment_scan_core_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_indicator_seven_segment_scan_core_checker
// Watches both channels of the floor indicator scan core. Each accepted
// floor/motion item is decoded into the digit drive that the core should
// produce: the glyph for the current scan position, the held direction glyph,
// inverted segments and the active-low digit select. Accepted results are
// compared in order against those expected drives.
// ----------------------------------------------------------------------------
module floor_indicator_seven_segment_scan_core_checker
  import fisc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [FLOOR_W-1:0]  in_floor,
  input  logic        [MOTION_W-1:0] in_motion,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic        [SEG_W-1:0]    out_segments_n,
  input  logic        [DIG_W-1:0]    out_digit_enable_n,
  output int                         fail_count,
  output int                         pending
);

  typedef struct packed {
    logic [SEG_W-1:0] seg_n;
    logic [DIG_W-1:0] enable_n;
  } digit_drive_t;

  localparam logic [SEG_W-1:0] SEGMENT_ROM [27] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71,
    8'h77, 8'h39, 8'h79, 8'h76, 8'h1E, 8'h38, 8'h73, 8'h3E,
    8'h80, 8'h40, 8'h00
  };

  logic [SCAN_W-1:0] scan_pos;
  glyph_t            dir_glyph;
  digit_drive_t      expected_drives[$];

  assign pending = expected_drives.size();

  function automatic digit_drive_t decode_floor(input logic signed [FLOOR_W-1:0] fl,
                                                input logic [MOTION_W-1:0] mo);
    int           mag;
    int           tens;
    logic         neg;
    logic         at_ground;
    glyph_t       units_g;
    glyph_t       tens_g;
    glyph_t       sel;
    digit_drive_t drive;
    neg       = fl[FLOOR_W-1];
    at_ground = (fl == 0);
    mag       = neg ? -int'(fl) : int'(fl);
    tens      = (mag % 100) / 10;
    units_g   = glyph_t'(mag % 10);
    if (at_ground) begin
      tens_g  = G_P;
      units_g = G_B;
    end else if (!neg) begin
      tens_g = (tens != 0) ? glyph_t'(tens) : G_BLANK;
    end else begin
      tens_g = G_DASH;
    end
    if (at_ground) begin
      if (mo == MOT_UP) dir_glyph = G_S;
      else if (mo == MOT_DOWN) dir_glyph = G_B;
      else dir_glyph = G_BLANK;
    end else begin
      case (mo)
        MOT_STOP:   dir_glyph = G_BLANK;
        MOT_UP:     dir_glyph = G_S;
        MOT_DOWN:   dir_glyph = G_B;
        MOT_GROUND: dir_glyph = neg ? G_S : G_B;
        default:    dir_glyph = dir_glyph;
      endcase
    end
    case (scan_pos)
      POS_UNITS: sel = units_g;
      POS_TENS:  sel = tens_g;
      POS_THIRD: sel = G_BLANK;
      default:   sel = dir_glyph;
    endcase
    drive.seg_n    = ~SEGMENT_ROM[sel];
    drive.enable_n = ~(DIG_W'(1) << scan_pos);
    scan_pos = scan_pos + 1'b1;
    return drive;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    digit_drive_t want;
    if (!rst_n) begin
      scan_pos  = POS_UNITS;
      dir_glyph = G_ZERO;
      expected_drives.delete();
    end else begin
      if (in_valid && !in_stall) expected_drives.push_back(decode_floor(in_floor, in_motion));
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("unexpected item seg_n=%h en_n=%h",
                                    out_segments_n, out_digit_enable_n));
        end else begin
          want = expected_drives.pop_front();
          if (out_segments_n !== want.seg_n)
            report_mismatch($sformatf("segments_n got %h want %h",
                                      out_segments_n, want.seg_n));
          if (out_digit_enable_n !== want.enable_n)
            report_mismatch($sformatf("digit_enable_n got %h want %h",
                                      out_digit_enable_n, want.enable_n));
        end
      end
    end
  end

endmodule

// ----- verif/floor_indicator_seven_segment_scan_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_indicator_seven_segment_scan_core_tb
// Drives floor/motion items into the scan core: a directed set covering the
// ground floor, both range ends, dropped hundreds, every motion code and the
// held direction glyph from reset, then random items. Sender and receiver
// pause at random in two of three phases, none in the last. The checker scores every result.
// ----------------------------------------------------------------------------
module floor_indicator_seven_segment_scan_core_tb;
  import fisc_pkg::*;

  localparam logic [MOTION_W-1:0] MOT_OTHER  = 3'd4;
  localparam logic [MOTION_W-1:0] MOT_RSVD5  = 3'd5;
  localparam logic [MOTION_W-1:0] MOT_RSVD6  = 3'd6;
  localparam logic [MOTION_W-1:0] MOT_RSVD7  = 3'd7;
  localparam int                  RAND_ITEMS = 450;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [FLOOR_W-1:0]  in_floor;
  logic        [MOTION_W-1:0] in_motion;
  logic                       out_valid;
  logic                       out_stall;
  logic        [SEG_W-1:0]    out_segments_n;
  logic        [DIG_W-1:0]    out_digit_enable_n;
  int                         fail_count;
  int                         pending;
  int                         send_gap_pct;
  int                         stall_pct;

  floor_indicator_seven_segment_scan_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_floor           (in_floor),
    .in_motion          (in_motion),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_segments_n     (out_segments_n),
    .out_digit_enable_n (out_digit_enable_n)
  );

  floor_indicator_seven_segment_scan_core_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_floor           (in_floor),
    .in_motion          (in_motion),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_segments_n     (out_segments_n),
    .out_digit_enable_n (out_digit_enable_n),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  task automatic send_floor(input logic signed [FLOOR_W-1:0] fl,
                            input logic [MOTION_W-1:0] mo);
    in_valid  <= 1'b1;
    in_floor  <= fl;
    in_motion <= mo;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
  endtask

  function automatic logic signed [FLOOR_W-1:0] pick_floor();
    logic signed [FLOOR_W-1:0] fl;
    case ($urandom_range(0, 7))
      0: fl = '0;
      1: fl = FLOOR_W'($urandom_range(0, 20) - 10);
      2: begin
        case ($urandom_range(0, 5))
          0: fl = 8'sd127;
          1: fl = -8'sd128;
          2: fl = -8'sd1;
          3: fl = 8'sd1;
          4: fl = 8'sd100;
          default: fl = -8'sd100;
        endcase
      end
      default: fl = FLOOR_W'($urandom);
    endcase
    return fl;
  endfunction

  function automatic logic [MOTION_W-1:0] pick_motion();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return MOTION_W'(r % 5);
    return MOTION_W'($urandom_range(MOT_RSVD5, MOT_RSVD7));
  endfunction

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_floor     = '0;
    in_motion    = MOT_STOP;
    send_gap_pct = 11;
    stall_pct    = 81;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // hold direction glyph from reset, then ground, extremes and every code
    send_floor(8'sd5, MOT_OTHER);
    send_floor(-8'sd3, MOT_RSVD5);
    send_floor(8'sd12, MOT_RSVD6);
    send_floor(8'sd7, MOT_RSVD7);
    send_floor(8'sd0, MOT_STOP);
    send_floor(8'sd0, MOT_UP);
    send_floor(8'sd0, MOT_DOWN);
    send_floor(8'sd0, MOT_GROUND);
    send_floor(8'sd0, MOT_OTHER);
    send_floor(8'sd127, MOT_UP);
    send_floor(-8'sd128, MOT_DOWN);
    send_floor(8'sd99, MOT_GROUND);
    send_floor(-8'sd1, MOT_GROUND);
    send_floor(8'sd100, MOT_OTHER);
    send_floor(8'sd105, MOT_RSVD6);
    send_floor(-8'sd100, MOT_GROUND);
    send_floor(8'sd10, MOT_UP);
    send_floor(-8'sd10, MOT_OTHER);
    send_floor(8'sd1, MOT_STOP);
    send_floor(-8'sd9, MOT_OTHER);
    send_floor(8'sd55, MOT_DOWN);
    send_floor(-8'sd128, MOT_OTHER);
    send_floor(8'sd0, MOT_RSVD5);
    send_floor(8'sd0, MOT_UP);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) begin
        send_gap_pct = 81;
        stall_pct    = 11;
      end else if (i == 2 * RAND_ITEMS / 3) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      send_floor(pick_floor(), pick_motion());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/fisc_pkg.sv
sv/fisc_decode.sv
sv/fisc_scan.sv
sv/floor_indicator_seven_segment_scan_core.sv
verif/floor_indicator_seven_segment_scan_core_checker.sv
verif/floor_indicator_seven_segment_scan_core_tb.sv
